FILE: rtl/rational_arithmetic_unit_defines.svh
// ----------------------------------------------------------------------------
// Rational arithmetic unit: assertion macros
// Shared check macros, clocked on i_clk and disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define RAU_CHECK(name, cond) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("rau check failed");
`define RAU_IMPLY(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rau implication failed");
`define RAU_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rau next-cycle check failed");
`else
`define RAU_CHECK(name, cond)
`define RAU_IMPLY(name, ante, cons)
`define RAU_NEXT(name, ante, cons)
`endif

`endif

FILE: rtl/rau_pkg.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Widths, operation codes, sequencer states and channel payload types.
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam int IN_WIDTH = 16;
    localparam int DEN_W    = IN_WIDTH - 1;
    localparam int MW       = IN_WIDTH + 1;      // multiplier operand width
    localparam int PW       = 2 * MW;            // multiplier product width
    localparam int WW       = 2 * IN_WIDTH + 1;  // working magnitude width
    localparam int SW       = WW + 2;            // shared subtractor width
    localparam int CW       = $clog2(WW + 1);    // shift and bit counters
    localparam int RN_W     = 32;
    localparam int RD_W     = 31;

    typedef enum logic [1:0] {
        K_MUL = 2'd0,
        K_ADD = 2'd1,
        K_SUB = 2'd2,
        K_CMP = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LG,    // gcd of the two denominators
        ST_LDB,   // b_den / g
        ST_LDA,   // a_den / g
        ST_LML,   // common denominator
        ST_LMA,   // scaled first numerator
        ST_LMB,   // scaled second numerator, combine
        ST_MN,    // product of numerators
        ST_MD,    // product of denominators
        ST_RG,    // gcd for reduction
        ST_RDN,   // numerator / g
        ST_RDD,   // denominator / g
        ST_RFIN,  // reduction finished
        ST_OUT
    } t_state;

    typedef struct packed {
        t_kind                      kind;
        logic signed [IN_WIDTH-1:0] a_num;
        logic [DEN_W-1:0]           a_den;
        logic signed [IN_WIDTH-1:0] b_num;
        logic [DEN_W-1:0]           b_den;
    } t_req;

    typedef struct packed {
        logic signed [RN_W-1:0] res_num;
        logic [RD_W-1:0]        res_den;
        logic                   is_equal;
        logic                   bad_input;
    } t_rsp;

endpackage

FILE: rtl/rational_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Multiplies, adds, subtracts or compares two fractions and reduces the result
// to lowest terms with a shared subtractor and a shared multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_valid/o_ready carries one request (kind, a_num, a_den,
//   b_num, b_den); output channel o_valid/i_ready returns one response.
//   o_ready is high only while the unit is idle; a request is taken when
//   i_valid and o_ready are both high.
//   A request with a zero denominator is answered in the next cycle. Otherwise
//   each gcd takes one subtract or shift per cycle and each division forms
//   a WW = 33 bit quotient on the shared subtractor. Multiply: 2 products,
//   1 gcd, 2 divisions. Add/subtract: 2 gcds, 4 divisions, 3 products.
//   Compare: 2 reductions. One request at a time.
//   The response is held in an output register until i_ready is seen; the
//   unit stays busy until then.
//   Reset (synchronous, i_rst_n low) returns the sequencer to idle and drops
//   any request in flight. The unit keeps no state between requests.
// ----------------------------------------------------------------------------
`include "rational_arithmetic_unit_defines.svh"

module rational_arithmetic_unit
    import rau_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_req i_req,
    output logic o_valid,
    input  logic i_ready,
    output t_rsp o_rsp
);

    t_state r_state, n_state;
    t_req   r_req, n_req;
    t_rsp   r_rsp, n_rsp;

    logic [WW-1:0] r_u, n_u, r_v, n_v;
    logic [CW-1:0] r_k, n_k;
    logic          r_gph, n_gph;
    logic [WW-1:0] r_rem, n_rem, r_quo, n_quo;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [WW-1:0] r_g, n_g, r_qa, n_qa, r_qb, n_qb;
    logic [WW-1:0] r_mag, n_mag, r_den, n_den;
    logic          r_neg, n_neg;
    logic          r_second, n_second;
    logic [WW-1:0] r_sv_mag, n_sv_mag, r_sv_den, n_sv_den;
    logic          r_sv_neg, n_sv_neg;

    // shared subtractor
    logic          in_div;
    logic [SW-1:0] sub_a, sub_b, diff;
    logic          borrow;

    // shared multiplier
    logic signed [MW-1:0] mul_a, mul_b;
    logic signed [PW-1:0] prod;
    logic [WW-1:0]        p_lo, p_abs;
    logic                 p_neg;

    // gcd step
    logic          g_done;
    logic [WW-1:0] g_val, g_u, g_v;
    logic [CW-1:0] g_k;
    logic          g_ph;

    // divider step
    logic          d_take, d_last;
    logic [WW-1:0] d_rem, d_quo;

    logic signed [WW-1:0] an_x, bn_x, sum, res_s;
    logic [WW-1:0]        an_abs, bn_abs, sum_abs;

    assign in_div = (r_state == ST_LDB) || (r_state == ST_LDA) ||
                    (r_state == ST_RDN) || (r_state == ST_RDD);

    always_comb begin
        if (in_div) begin
            sub_a = {1'b0, r_rem, r_quo[WW-1]};
        end else begin
            sub_a = {2'b00, r_u};
        end
        if (in_div) begin
            sub_b = {2'b00, r_g};
        end else begin
            sub_b = {2'b00, r_v};
        end
    end
    assign diff   = sub_a - sub_b;
    assign borrow = diff[SW-1];

    // binary gcd: strip common twos, then subtract odd from odd
    always_comb begin
        g_u    = r_u;
        g_v    = r_v;
        g_k    = r_k;
        g_ph   = r_gph;
        g_done = (r_u == '0);
        g_val  = r_v << r_k;
        if (!g_done) begin
            if (!r_gph) begin
                if (!r_u[0] && !r_v[0]) begin
                    g_u = r_u >> 1;
                    g_v = r_v >> 1;
                    g_k = r_k + CW'(1);
                end else begin
                    g_ph = 1'b1;
                end
            end else if (!r_u[0]) begin
                g_u = r_u >> 1;
            end else if (!r_v[0]) begin
                g_v = r_v >> 1;
            end else if (!borrow) begin
                g_u = diff[WW-1:0];
            end else begin
                g_v = WW'(-diff);
            end
        end
    end

    // restoring division, one quotient bit per cycle
    assign d_take = !borrow;
    assign d_rem  = d_take ? diff[WW-1:0] : {r_rem[WW-2:0], r_quo[WW-1]};
    assign d_quo  = {r_quo[WW-2:0], d_take};
    assign d_last = (r_cnt == '0);

    always_comb begin
        case (r_state)
            ST_LML: begin
                mul_a = MW'({1'b0, r_qa[DEN_W-1:0]});
                mul_b = MW'({1'b0, r_req.b_den});
            end
            ST_LMA: begin
                mul_a = MW'(r_req.a_num);
                mul_b = MW'({1'b0, r_qb[DEN_W-1:0]});
            end
            ST_LMB: begin
                mul_a = MW'(r_req.b_num);
                mul_b = MW'({1'b0, r_qa[DEN_W-1:0]});
            end
            ST_MN: begin
                mul_a = MW'(r_req.a_num);
                mul_b = MW'(r_req.b_num);
            end
            default: begin
                mul_a = MW'({1'b0, r_req.a_den});
                mul_b = MW'({1'b0, r_req.b_den});
            end
        endcase
    end
    assign prod  = mul_a * mul_b;
    assign p_lo  = prod[WW-1:0];
    assign p_neg = prod[PW-1];
    assign p_abs = p_neg ? WW'(-p_lo) : p_lo;

    assign an_x   = WW'(i_req.a_num);
    assign an_abs = i_req.a_num[IN_WIDTH-1] ? WW'(-an_x) : an_x;
    assign bn_x   = WW'(r_req.b_num);
    assign bn_abs = r_req.b_num[IN_WIDTH-1] ? WW'(-bn_x) : bn_x;

    assign sum     = (r_req.kind == K_ADD) ? $signed(r_mag) + $signed(p_lo)
                                           : $signed(r_mag) - $signed(p_lo);
    assign sum_abs = sum[WW-1] ? WW'(-sum) : sum;
    assign res_s   = r_neg ? $signed(WW'(-r_mag)) : $signed(r_mag);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req    <= n_req;
        r_rsp    <= n_rsp;
        r_u      <= n_u;
        r_v      <= n_v;
        r_k      <= n_k;
        r_gph    <= n_gph;
        r_rem    <= n_rem;
        r_quo    <= n_quo;
        r_cnt    <= n_cnt;
        r_g      <= n_g;
        r_qa     <= n_qa;
        r_qb     <= n_qb;
        r_mag    <= n_mag;
        r_den    <= n_den;
        r_neg    <= n_neg;
        r_second <= n_second;
        r_sv_mag <= n_sv_mag;
        r_sv_den <= n_sv_den;
        r_sv_neg <= n_sv_neg;
    end

    always_comb begin
        n_state  = r_state;
        n_req    = r_req;
        n_rsp    = r_rsp;
        n_u      = r_u;
        n_v      = r_v;
        n_k      = r_k;
        n_gph    = r_gph;
        n_rem    = r_rem;
        n_quo    = r_quo;
        n_cnt    = r_cnt;
        n_g      = r_g;
        n_qa     = r_qa;
        n_qb     = r_qb;
        n_mag    = r_mag;
        n_den    = r_den;
        n_neg    = r_neg;
        n_second = r_second;
        n_sv_mag = r_sv_mag;
        n_sv_den = r_sv_den;
        n_sv_neg = r_sv_neg;

        if (r_state == ST_LG || r_state == ST_RG) begin
            n_u   = g_u;
            n_v   = g_v;
            n_k   = g_k;
            n_gph = g_ph;
        end
        if (in_div) begin
            n_rem = d_rem;
            n_quo = d_quo;
            n_cnt = r_cnt - CW'(1);
        end

        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_req = i_req;
                    n_k   = '0;
                    n_gph = 1'b0;
                    if (i_req.a_den == '0 || i_req.b_den == '0) begin
                        n_rsp           = '0;
                        n_rsp.bad_input = 1'b1;
                        n_state         = ST_OUT;
                    end else begin
                        case (i_req.kind)
                            K_MUL: begin
                                n_state = ST_MN;
                            end
                            K_CMP: begin
                                n_second = 1'b0;
                                n_mag    = an_abs;
                                n_neg    = i_req.a_num[IN_WIDTH-1];
                                n_den    = WW'(i_req.a_den);
                                n_u      = an_abs;
                                n_v      = WW'(i_req.a_den);
                                n_state  = ST_RG;
                            end
                            default: begin
                                n_u     = WW'(i_req.a_den);
                                n_v     = WW'(i_req.b_den);
                                n_state = ST_LG;
                            end
                        endcase
                    end
                end
            end
            ST_LG: begin
                if (g_done) begin
                    n_g     = g_val;
                    n_rem   = '0;
                    n_quo   = WW'(r_req.b_den);
                    n_cnt   = CW'(WW - 1);
                    n_state = ST_LDB;
                end
            end
            ST_LDB: begin
                if (d_last) begin
                    n_qb    = d_quo;
                    n_rem   = '0;
                    n_quo   = WW'(r_req.a_den);
                    n_cnt   = CW'(WW - 1);
                    n_state = ST_LDA;
                end
            end
            ST_LDA: begin
                if (d_last) begin
                    n_qa    = d_quo;
                    n_state = ST_LML;
                end
            end
            ST_LML: begin
                n_den   = p_lo;
                n_state = ST_LMA;
            end
            ST_LMA: begin
                n_mag   = p_lo;  // hold the signed first term
                n_state = ST_LMB;
            end
            ST_LMB: begin
                n_mag   = sum_abs;
                n_neg   = sum[WW-1];
                n_u     = sum_abs;
                n_v     = r_den;
                n_k     = '0;
                n_gph   = 1'b0;
                n_state = ST_RG;
            end
            ST_MN: begin
                n_mag   = p_abs;
                n_neg   = p_neg;
                n_state = ST_MD;
            end
            ST_MD: begin
                n_den   = p_lo;
                n_u     = r_mag;
                n_v     = p_lo;
                n_k     = '0;
                n_gph   = 1'b0;
                n_state = ST_RG;
            end
            ST_RG: begin
                if (g_done) begin
                    n_g     = g_val;
                    n_rem   = '0;
                    n_quo   = r_mag;
                    n_cnt   = CW'(WW - 1);
                    n_state = ST_RDN;
                end
            end
            ST_RDN: begin
                if (d_last) begin
                    n_mag   = d_quo;
                    n_rem   = '0;
                    n_quo   = r_den;
                    n_cnt   = CW'(WW - 1);
                    n_state = ST_RDD;
                end
            end
            ST_RDD: begin
                if (d_last) begin
                    n_den   = d_quo;
                    n_state = ST_RFIN;
                end
            end
            ST_RFIN: begin
                if (r_req.kind == K_CMP && !r_second) begin
                    // keep the reduced first operand, reduce the second
                    n_sv_mag = r_mag;
                    n_sv_neg = r_neg;
                    n_sv_den = r_den;
                    n_second = 1'b1;
                    n_mag    = bn_abs;
                    n_neg    = r_req.b_num[IN_WIDTH-1];
                    n_den    = WW'(r_req.b_den);
                    n_u      = bn_abs;
                    n_v      = WW'(r_req.b_den);
                    n_k      = '0;
                    n_gph    = 1'b0;
                    n_state  = ST_RG;
                end else begin
                    n_rsp = '0;
                    if (r_req.kind == K_CMP) begin
                        n_rsp.is_equal = (r_mag == r_sv_mag) && (r_neg == r_sv_neg) &&
                                         (r_den == r_sv_den);
                    end else begin
                        n_rsp.res_num = RN_W'(res_s);
                        n_rsp.res_den = RD_W'(r_den);
                    end
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (i_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_ready = (r_state == ST_IDLE);
    assign o_valid = (r_state == ST_OUT);
    assign o_rsp   = r_rsp;

    `RAU_CHECK(a_busy_excl, !(o_ready && o_valid))
    `RAU_NEXT(a_bad_fast, i_valid && o_ready && (i_req.a_den == '0 || i_req.b_den == '0),
              o_valid && o_rsp.bad_input)
    `RAU_IMPLY(a_div_nonzero, in_div, r_g != '0)
    `RAU_IMPLY(a_den_nonzero, r_state == ST_RFIN, r_den != '0)

endmodule
